>>> hdl/length_prefixed_envelope_deframer_assert.svh
// Assertion macros used by the envelope deframer parser.
// Depends on nothing; define ASSERT_OFF to drop every check.
`ifndef LENGTH_PREFIXED_ENVELOPE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_ENVELOPE_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPED_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lped assertion failed");
`define LPED_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lped assertion failed");
`else
`define LPED_ASSERT(label, clk, rst, prop)
`define LPED_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

>>> hdl/lped_pkg.sv
// Types and constants shared by the envelope deframer modules.
// Depends on nothing.
package lped_pkg;

   localparam int WORD_BITS = 32;
   localparam int BYTE_BITS = 8;

   localparam logic [1:0] KIND_VERSION  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
   localparam logic [1:0] KIND_EMPTY    = 2'd2;
   localparam logic [1:0] KIND_TRUNCATE = 2'd3;

   localparam logic [2:0] SECTION_VERSION = 3'd0;
   localparam logic [2:0] SECTION_SENDER  = 3'd1;
   localparam logic [2:0] SECTION_AAD     = 3'd5;

   localparam logic [1:0] HEADER_LAST_BYTE = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  section;
      logic [31:0] value;
      logic        section_last;
      logic        envelope_done;
      logic        truncated;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } item_type;

endpackage

>>> hdl/lped_in_stage.sv
// Input register of the envelope deframer.
// Depends on lped_pkg for the request and item types.
module lped_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lped_pkg::req_type req_data,
   input  logic              advance,
   output lped_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   lped_pkg::req_type data_ff;
   logic              take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff <= req_data;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

>>> hdl/lped_parser.sv
// Framing state and per-byte result logic of the envelope deframer.
// Depends on lped_pkg and the assertion macro header.
`include "length_prefixed_envelope_deframer_assert.svh"

module lped_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  lped_pkg::item_type    item,
   input  logic                  advance,
   output lped_pkg::result_type  result
);

   logic [2:0]  section_ff,   section_in;
   logic        in_header_ff, in_header_in;
   logic [1:0]  hdr_cnt_ff,   hdr_cnt_in;
   logic [31:0] acc_ff,       acc_in;
   logic [31:0] remain_ff,    remain_in;
   logic        done_ff,      done_in;

   logic [31:0] acc_shift;
   logic        step;
   logic        finish;

   assign step      = item.valid && advance;
   assign acc_shift = {acc_ff[lped_pkg::WORD_BITS-lped_pkg::BYTE_BITS-1:0],
                       item.data.data_byte};

   always_comb begin
      section_in   = section_ff;
      in_header_in = in_header_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      acc_in       = acc_ff;
      remain_in    = remain_ff;
      done_in      = done_ff;
      finish       = 1'b0;
      result       = '0;

      if (!done_ff) begin
         if (in_header_ff) begin
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
            if (hdr_cnt_ff == lped_pkg::HEADER_LAST_BYTE) begin
               acc_in = '0;
               if (section_ff == lped_pkg::SECTION_VERSION) begin
                  result.valid        = 1'b1;
                  result.data.kind    = lped_pkg::KIND_VERSION;
                  result.data.section = lped_pkg::SECTION_VERSION;
                  result.data.value   = acc_shift;
                  section_in          = lped_pkg::SECTION_SENDER;
               end else if (acc_shift == '0) begin
                  result.valid        = 1'b1;
                  result.data.kind    = lped_pkg::KIND_EMPTY;
                  result.data.section = section_ff;
                  finish              = 1'b1;
               end else begin
                  remain_in    = acc_shift;
                  in_header_in = 1'b0;
               end
            end else begin
               acc_in = acc_shift;
            end
         end else begin
            result.valid        = 1'b1;
            result.data.kind    = lped_pkg::KIND_PAYLOAD;
            result.data.section = section_ff;
            result.data.value   = {24'd0, item.data.data_byte};
            remain_in           = remain_ff - 32'd1;
            finish              = (remain_ff == 32'd1);
         end
      end

      if (finish) begin
         result.data.section_last = 1'b1;
         if (section_ff >= lped_pkg::SECTION_AAD) begin
            done_in                   = 1'b1;
            result.data.envelope_done = 1'b1;
         end else begin
            section_in = section_ff + 3'd1;
         end
         in_header_in = 1'b1;
         hdr_cnt_in   = '0;
         acc_in       = '0;
      end

      if (item.data.buffer_end) begin
         if (!done_in) begin
            if (!result.valid) begin
               result.valid        = 1'b1;
               result.data.kind    = lped_pkg::KIND_TRUNCATE;
               result.data.section = section_in;
            end
            result.data.truncated = 1'b1;
         end
         section_in   = lped_pkg::SECTION_VERSION;
         in_header_in = 1'b1;
         hdr_cnt_in   = '0;
         acc_in       = '0;
         remain_in    = '0;
         done_in      = 1'b0;
      end

      result.valid = result.valid && item.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff   <= lped_pkg::SECTION_VERSION;
         in_header_ff <= 1'b1;
         hdr_cnt_ff   <= '0;
         acc_ff       <= '0;
         remain_ff    <= '0;
         done_ff      <= 1'b0;
      end else if (step) begin
         section_ff   <= section_in;
         in_header_ff <= in_header_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         acc_ff       <= acc_in;
         remain_ff    <= remain_in;
         done_ff      <= done_in;
      end
   end

   `LPED_ASSERT(a_section_range, clock, reset, section_ff <= lped_pkg::SECTION_AAD)
   `LPED_ASSERT(a_done_in_aad, clock, reset, !done_ff || section_ff == lped_pkg::SECTION_AAD)
   `LPED_ASSERT(a_body_has_bytes, clock, reset, in_header_ff || remain_ff != '0)
   `LPED_ASSERT_NEXT(a_end_restarts, clock, reset, step && item.data.buffer_end, section_ff == lped_pkg::SECTION_VERSION && !done_ff)

endmodule

>>> hdl/lped_out_reg.sv
// Result register of the envelope deframer, held while the receiver stalls.
// Depends on lped_pkg for the response and result types.
module lped_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  lped_pkg::result_type result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lped_pkg::rsp_type    rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   lped_pkg::rsp_type data_ff;

   assign advance  = !(valid_ff && rsp_stall);
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> hdl/length_prefixed_envelope_deframer.sv
// Top level of the length-prefixed envelope deframer.
// Depends on lped_pkg, lped_in_stage, lped_parser and lped_out_reg.
//
// The request channel carries one envelope byte per transaction together with
// a flag that marks the final byte of the buffer. The response channel carries
// at most one result per byte: the version word, a tagged payload byte, an
// empty-section marker, or a truncation notice.
// Each byte is captured in an input register, parsed by the framing logic, and
// its result is written to an output register, from which it drives rsp_valid.
// One byte is accepted every cycle while rsp_stall does not hold the output
// register, as each byte takes a single pass through the framing state; bytes
// that give no result simply leave no response.
// When the receiver asserts rsp_stall with a result waiting, the output
// register holds, the parser pauses, and req_stall rises once the input
// register is also full; nothing is lost or repeated.
// Synchronous reset empties both registers and returns the framing state to
// the start of an envelope. A byte flagged as the buffer end does the same
// after its result, so the next byte starts a new envelope.
module length_prefixed_envelope_deframer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lped_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lped_pkg::rsp_type rsp_data
);

   lped_pkg::item_type   item;
   lped_pkg::result_type result;
   logic                 advance;

   lped_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .item      (item)
   );

   lped_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   lped_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
